// ===== hdl/evls_pkg.sv =====
`default_nettype none

package evls_pkg;

   // Store geometry: eight byte-wide banks, address bits [2:0] select the bank.
   localparam int StoreBytes = 1024;
   localparam int Lanes      = 8;
   localparam int LaneW      = $clog2(Lanes);
   localparam int AddrW      = $clog2(StoreBytes);
   localparam int RowW       = AddrW - LaneW;
   localparam int Rows       = StoreBytes / Lanes;

   // Field widths.
   localparam int OffsetW  = 10;
   localparam int LengthW  = 11;
   localparam int IndexW   = 11;
   localparam int DataW    = 64;
   localparam int CsrDataW = 11;
   localparam int CsrIdxW  = 2;
   localparam int SumW     = ((AddrW > IndexW) ? AddrW : IndexW) + 2;

   // Reset value of the window length.
   localparam logic [LengthW-1:0] LengthReset = LengthW'(1024);

   typedef enum logic [1:0] {
      StOk       = 2'd0,
      StRange    = 2'd1,
      StDetached = 2'd2
   } status_type;

   typedef enum logic [CsrIdxW-1:0] {
      CsrWindowOffset   = 2'd0,
      CsrWindowLength   = 2'd1,
      CsrBufferDetached = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              op;
      logic [1:0]        size_code;
      logic              sign_extend;
      logic              little_endian;
      logic [IndexW-1:0] index;
      logic [DataW-1:0]  write_data;
   } req_type;

   typedef struct packed {
      logic            we;
      logic [RowW-1:0] row;
      logic [7:0]      wdata;
   } bank_cmd_type;

   typedef struct packed {
      status_type       status;
      logic             op;
      logic [1:0]       size_code;
      logic             sign_extend;
      logic             little_endian;
      logic [LaneW-1:0] base_lane;
   } fmt_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/evls_bank.sv =====
`default_nettype none

// One byte-wide bank: one write or read per cycle, registered read data.
module evls_bank (
   input  wire logic                  clock,
   input  wire evls_pkg::bank_cmd_type cmd,
   output logic [7:0]                 rd_data
);

   logic [7:0] mem [evls_pkg::Rows];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.row] <= cmd.wdata;
      end
      rd_data_ff <= mem[cmd.row];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/evls_access.sv =====
`default_nettype none

// Window checks and per-bank address / write lane steering.
module evls_access (
   input  wire logic                                req_valid,
   input  wire evls_pkg::req_type                   req,
   input  wire logic [evls_pkg::OffsetW-1:0]        window_offset,
   input  wire logic [evls_pkg::LengthW-1:0]        window_length,
   input  wire logic                                buffer_detached,
   output evls_pkg::bank_cmd_type                   bank_cmd [evls_pkg::Lanes],
   output evls_pkg::fmt_ctl_type                    fmt_ctl
);

   logic [evls_pkg::LaneW:0]    size;
   logic [evls_pkg::LaneW-1:0]  size_m1;
   logic [evls_pkg::IndexW:0]   rel_end;
   logic [evls_pkg::SumW-1:0]   base;
   logic [evls_pkg::SumW-1:0]   abs_end;
   logic [evls_pkg::RowW-1:0]   base_row;
   logic [evls_pkg::LaneW-1:0]  base_lane;
   evls_pkg::status_type        status;

   assign size      = (evls_pkg::LaneW+1)'(1) << req.size_code;
   assign size_m1   = evls_pkg::LaneW'(size - (evls_pkg::LaneW+1)'(1));
   assign rel_end   = (evls_pkg::IndexW+1)'(req.index) + (evls_pkg::IndexW+1)'(size);
   assign base      = evls_pkg::SumW'(window_offset) + evls_pkg::SumW'(req.index);
   assign abs_end   = base + evls_pkg::SumW'(size);
   assign base_row  = base[evls_pkg::AddrW-1:evls_pkg::LaneW];
   assign base_lane = base[evls_pkg::LaneW-1:0];

   // Detached wins over range; range covers both window end and store end.
   always_comb begin
      if (buffer_detached) begin
         status = evls_pkg::StDetached;
      end else if (rel_end > (evls_pkg::IndexW+1)'(window_length)) begin
         status = evls_pkg::StRange;
      end else if (abs_end > evls_pkg::SumW'(evls_pkg::StoreBytes)) begin
         status = evls_pkg::StRange;
      end else begin
         status = evls_pkg::StOk;
      end
   end

   // Bank b holds byte offset k = b - base_lane of the access; it wraps to
   // the next row when b sits below the starting lane.
   always_comb begin
      logic [evls_pkg::LaneW-1:0] k;
      logic [evls_pkg::LaneW-1:0] byte_sel;
      logic                       active;
      logic                       wrap;
      for (int b = 0; b < evls_pkg::Lanes; b++) begin
         k        = evls_pkg::LaneW'(b) - base_lane;
         active   = {1'b0, k} < size;
         wrap     = evls_pkg::LaneW'(b) < base_lane;
         byte_sel = req.little_endian ? k : (size_m1 - k);
         bank_cmd[b].we    = req_valid & req.op & active & (status == evls_pkg::StOk);
         bank_cmd[b].row   = base_row + evls_pkg::RowW'(wrap);
         bank_cmd[b].wdata = req.write_data[8*byte_sel +: 8];
      end
   end

   assign fmt_ctl.status        = status;
   assign fmt_ctl.op            = req.op;
   assign fmt_ctl.size_code     = req.size_code;
   assign fmt_ctl.sign_extend   = req.sign_extend;
   assign fmt_ctl.little_endian = req.little_endian;
   assign fmt_ctl.base_lane     = base_lane;

endmodule

`default_nettype wire

// ===== hdl/evls_format.sv =====
`default_nettype none

// Byte reorder of bank read data, sign extension, zeroing on error or write.
module evls_format (
   input  wire evls_pkg::fmt_ctl_type          fmt_ctl,
   input  wire logic [7:0]                     bank_data [evls_pkg::Lanes],
   output logic [evls_pkg::DataW-1:0]          read_data,
   output evls_pkg::status_type                status
);

   logic [evls_pkg::LaneW:0]   size;
   logic [evls_pkg::LaneW-1:0] size_m1;
   logic [evls_pkg::DataW-1:0] value;
   logic [evls_pkg::DataW-1:0] ext;

   assign size    = (evls_pkg::LaneW+1)'(1) << fmt_ctl.size_code;
   assign size_m1 = evls_pkg::LaneW'(size - (evls_pkg::LaneW+1)'(1));

   always_comb begin
      logic [evls_pkg::LaneW-1:0] k;
      logic [evls_pkg::LaneW-1:0] lane;
      for (int i = 0; i < evls_pkg::Lanes; i++) begin
         k    = fmt_ctl.little_endian ? evls_pkg::LaneW'(i) : (size_m1 - evls_pkg::LaneW'(i));
         lane = fmt_ctl.base_lane + k;
         value[8*i +: 8] = ((evls_pkg::LaneW+1)'(i) < size) ? bank_data[lane] : 8'h00;
      end
   end

   always_comb begin
      case (fmt_ctl.size_code)
         2'd0:    ext = {{56{value[7]}},  value[7:0]};
         2'd1:    ext = {{48{value[15]}}, value[15:0]};
         2'd2:    ext = {{32{value[31]}}, value[31:0]};
         default: ext = value;
      endcase
   end

   assign status    = fmt_ctl.status;
   assign read_data = (fmt_ctl.status != evls_pkg::StOk || fmt_ctl.op) ? '0 :
                      (fmt_ctl.sign_extend ? ext : value);

endmodule

`default_nettype wire

// ===== hdl/endian_view_load_store_top.sv =====
`default_nettype none

// Channel   Handshake              Payload
// request   start / busy           req_op, req_size_code, req_sign_extend,
//                                  req_little_endian, req_index, req_write_data
// response  rsp_valid (strobe)     rsp_read_data, rsp_status
// csr       csr_valid / csr_ready  csr_index, csr_data
//
// A request is taken every cycle while busy is low; its response strobes after
// the input register, the bank access with registered read and the result
// register. After reset busy stays high while a sweep writes zero to one row
// of all eight banks per cycle, Rows (128) rows; csr writes are taken then.
// The receiver cannot stall: each response is shown for exactly one cycle.
module endian_view_load_store_top (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_op,
   input  wire logic [1:0]                     req_size_code,
   input  wire logic                           req_sign_extend,
   input  wire logic                           req_little_endian,
   input  wire logic [evls_pkg::IndexW-1:0]    req_index,
   input  wire logic [evls_pkg::DataW-1:0]     req_write_data,

   output logic                                rsp_valid,
   output logic [evls_pkg::DataW-1:0]          rsp_read_data,
   output logic [1:0]                          rsp_status,

   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [evls_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [evls_pkg::CsrDataW-1:0]  csr_data
);

   // Window registers.
   logic [evls_pkg::OffsetW-1:0] window_offset_ff;
   logic [evls_pkg::LengthW-1:0] window_length_ff;
   logic                         buffer_detached_ff;

   // Clearing sweep.
   logic                         clear_active_ff, clear_active_in;
   logic [evls_pkg::RowW-1:0]    clear_row_ff, clear_row_in;

   // Stage 1: request register.
   evls_pkg::req_type            req_ff, req_in;
   logic                         req_vld_ff;

   // Stage 2: bank access; read data lands in the banks' own registers.
   evls_pkg::fmt_ctl_type        fmt_ctl_ff;
   evls_pkg::fmt_ctl_type        fmt_ctl_in;
   logic                         fmt_vld_ff;
   evls_pkg::bank_cmd_type       acc_cmd [evls_pkg::Lanes];
   evls_pkg::bank_cmd_type       bank_cmd [evls_pkg::Lanes];
   logic [7:0]                   bank_data [evls_pkg::Lanes];

   // Stage 3: response register.
   logic                         rsp_valid_ff;
   logic [evls_pkg::DataW-1:0]   rsp_read_data_ff, rsp_read_data_in;
   evls_pkg::status_type         rsp_status_ff, rsp_status_in;

   logic                         req_take;

   assign busy      = clear_active_ff;
   assign req_take  = start & ~clear_active_ff;
   assign csr_ready = 1'b1;

   // csr writes; an index past the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_offset_ff   <= '0;
         window_length_ff   <= evls_pkg::LengthReset;
         buffer_detached_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            evls_pkg::CsrWindowOffset:
               window_offset_ff <= csr_data[evls_pkg::OffsetW-1:0];
            evls_pkg::CsrWindowLength:
               window_length_ff <= csr_data[evls_pkg::LengthW-1:0];
            evls_pkg::CsrBufferDetached:
               buffer_detached_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Clearing sweep: one row of every bank per cycle.
   always_comb begin
      clear_active_in = clear_active_ff;
      clear_row_in    = clear_row_ff;
      if (clear_active_ff) begin
         clear_row_in = clear_row_ff + evls_pkg::RowW'(1);
         if (clear_row_ff == evls_pkg::RowW'(evls_pkg::Rows - 1)) begin
            clear_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_row_ff    <= '0;
      end else begin
         clear_active_ff <= clear_active_in;
         clear_row_ff    <= clear_row_in;
      end
   end

   // Stage 1.
   assign req_in.op            = req_op;
   assign req_in.size_code     = req_size_code;
   assign req_in.sign_extend   = req_sign_extend;
   assign req_in.little_endian = req_little_endian;
   assign req_in.index         = req_index;
   assign req_in.write_data    = req_write_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_take;
      end
      if (req_take) begin
         req_ff <= req_in;
      end
   end

   // Stage 2: checks, lane steering, bank access.
   evls_access u_access (
      .req_valid       (req_vld_ff),
      .req             (req_ff),
      .window_offset   (window_offset_ff),
      .window_length   (window_length_ff),
      .buffer_detached (buffer_detached_ff),
      .bank_cmd        (acc_cmd),
      .fmt_ctl         (fmt_ctl_in)
   );

   // The sweep owns the banks until it ends; no request is in flight then.
   always_comb begin
      for (int b = 0; b < evls_pkg::Lanes; b++) begin
         if (clear_active_ff) begin
            bank_cmd[b].we    = 1'b1;
            bank_cmd[b].row   = clear_row_ff;
            bank_cmd[b].wdata = 8'h00;
         end else begin
            bank_cmd[b] = acc_cmd[b];
         end
      end
   end

   for (genvar g = 0; g < evls_pkg::Lanes; g++) begin : g_bank
      evls_bank u_bank (
         .clock   (clock),
         .cmd     (bank_cmd[g]),
         .rd_data (bank_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_vld_ff <= 1'b0;
      end else begin
         fmt_vld_ff <= req_vld_ff;
      end
      fmt_ctl_ff <= fmt_ctl_in;
   end

   // Stage 3: reorder, extend, register the response.
   evls_format u_format (
      .fmt_ctl   (fmt_ctl_ff),
      .bank_data (bank_data),
      .read_data (rsp_read_data_in),
      .status    (rsp_status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fmt_vld_ff;
      end
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire
